>>> hw/rtl/mtbe_pkg.sv
`timescale 1ns / 1ps

package mtbe_pkg;

    localparam int DATA_W  = 32;
    localparam int CELL_W  = 64;
    localparam int CNT_W   = 6;
    localparam int CCNT_W  = 7;
    localparam int SPEED_W = 16;
    localparam int CRC_W   = 16;
    localparam int HALF_W  = DATA_W / 2;

    localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_PRESET = 16'hffff;

    typedef enum logic [1:0] {
        FUNC_EMIT   = 2'd0,
        FUNC_GAP    = 2'd1,
        FUNC_PRESET = 2'd2,
        FUNC_CRC    = 2'd3
    } t_func;

    typedef logic [2:0] t_enc;

    localparam t_enc ENC_RAW      = 3'd0;
    localparam t_enc ENC_MFM      = 3'd1;
    localparam t_enc ENC_EVEN     = 3'd2;
    localparam t_enc ENC_ODD      = 3'd3;
    localparam t_enc ENC_EVEN_ODD = 3'd4;
    localparam t_enc ENC_ODD_EVEN = 3'd5;

endpackage

>>> hw/rtl/mtbe_in_if.sv
`timescale 1ns / 1ps

interface mtbe_in_if;

    logic                                valid;
    logic                                ready;
    mtbe_pkg::t_func                     func;
    mtbe_pkg::t_enc                      encoding;
    logic [mtbe_pkg::CNT_W-1:0]          bit_count;
    logic [mtbe_pkg::DATA_W-1:0]         data_word;
    logic [mtbe_pkg::SPEED_W-1:0]        cell_speed;

    modport source (
        output valid, func, encoding, bit_count, data_word, cell_speed,
        input  ready
    );

    modport sink (
        input  valid, func, encoding, bit_count, data_word, cell_speed,
        output ready
    );

endinterface

>>> hw/rtl/mtbe_out_if.sv
`timescale 1ns / 1ps

interface mtbe_out_if;

    logic                                valid;
    logic                                ready;
    logic [mtbe_pkg::CELL_W-1:0]         cells;
    logic [mtbe_pkg::CCNT_W-1:0]         cell_count;
    logic [mtbe_pkg::SPEED_W-1:0]        speed_out;
    logic [mtbe_pkg::CRC_W-1:0]          crc_now;

    modport source (
        output valid, cells, cell_count, speed_out, crc_now,
        input  ready
    );

    modport sink (
        input  valid, cells, cell_count, speed_out, crc_now,
        output ready
    );

endinterface

>>> hw/rtl/mfm_track_bit_encoder.sv
`timescale 1ns / 1ps

// MFM track bit encoder with running CRC-16-CCITT.
// i_in carries one command per transaction: emit data bits (raw, MFM, even,
// odd, even-odd, odd-even), emit MFM zero gap bits, preset the CRC, or emit
// the CRC as 16 MFM bits. o_out returns one transaction per command with the
// cells (first cell at bit cell_count-1), their count, the speed tag and the
// CRC after the command.
// A command passes from the input register on i_in to the result register;
// o_out.valid rises once the result register loads it. Throughput: one command
// per cycle while o_out does not stall; the whole command, including the CRC
// over up to 32 data bits, is one pass of logic between the two registers.
// Reset clears both valid flags, the CRC (to 0) and the previous data bit.
// When o_out stalls, the result register holds and i_in still takes one
// more command into the input register; i_in.ready drops only once both
// registers are full.

module mfm_track_bit_encoder #(
    parameter int MAX_DATA_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtbe_in_if.sink    i_in,
    mtbe_out_if.source o_out
);

    import mtbe_pkg::*;

    logic                r_in_valid;
    t_func               r_func;
    t_enc                r_enc;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_data;
    logic [SPEED_W-1:0]  r_speed;

    logic                r_out_valid;
    logic [CELL_W-1:0]   r_cells;
    logic [CCNT_W-1:0]   r_ccount;
    logic [SPEED_W-1:0]  r_speed_out;

    logic [CRC_W-1:0]    r_crc;
    logic                r_last;

    logic                advance;

    logic [CNT_W-1:0]    n_sat;
    logic [CNT_W-2:0]    half;
    logic [HALF_W-1:0]   odd_bits;
    logic [HALF_W-1:0]   even_bits;
    logic [HALF_W-1:0]   first_half;
    logic [HALF_W-1:0]   second_half;
    logic [DATA_W-1:0]   pair_bits;
    logic [DATA_W-1:0]   seq_v;
    logic [CNT_W-1:0]    seq_m;
    logic                seq_raw;
    logic                crc_en;
    logic                crc_preset;
    logic [DATA_W-1:0]   len_mask;
    logic [DATA_W-1:0]   v_m;
    logic [DATA_W:0]     ext_mask;
    logic [DATA_W:0]     ext_v;
    logic                prev;
    logic [CELL_W-1:0]   mfm_cells;
    logic [CRC_W-1:0]    n_crc;
    logic [CELL_W-1:0]   n_cells;
    logic [CCNT_W-1:0]   n_count;
    logic                n_last;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;

    assign o_out.valid      = r_out_valid;
    assign o_out.cells      = r_cells;
    assign o_out.cell_count = r_ccount;
    assign o_out.speed_out  = r_speed_out;
    assign o_out.crc_now    = r_crc;

    always_comb begin
        n_sat = (r_cnt > CNT_W'(MAX_DATA_BITS)) ? CNT_W'(MAX_DATA_BITS) : r_cnt;
        half  = n_sat[CNT_W-1:1];

        for (int i = 0; i < HALF_W; i++) begin
            odd_bits[i]  = r_data[2*i]   & (i < half);
            even_bits[i] = r_data[2*i+1] & (i < half);
        end

        if (r_enc == ENC_EVEN_ODD) begin
            first_half  = even_bits;
            second_half = odd_bits;
        end else begin
            first_half  = odd_bits;
            second_half = even_bits;
        end
        pair_bits = ({{(DATA_W-HALF_W){1'b0}}, first_half} << half)
                  | {{(DATA_W-HALF_W){1'b0}}, second_half};

        seq_v      = '0;
        seq_m      = '0;
        seq_raw    = 1'b0;
        crc_en     = 1'b0;
        crc_preset = 1'b0;

        unique case (r_func)
            FUNC_EMIT: begin
                crc_en = 1'b1;
                unique case (r_enc)
                    ENC_MFM: begin
                        seq_v = r_data;
                        seq_m = n_sat;
                    end
                    ENC_EVEN: begin
                        seq_v = {{(DATA_W-HALF_W){1'b0}}, even_bits};
                        seq_m = {1'b0, half};
                    end
                    ENC_ODD: begin
                        seq_v = {{(DATA_W-HALF_W){1'b0}}, odd_bits};
                        seq_m = {1'b0, half};
                    end
                    ENC_EVEN_ODD, ENC_ODD_EVEN: begin
                        seq_v = pair_bits;
                        seq_m = {half, 1'b0};
                    end
                    default: begin
                        seq_v   = r_data;
                        seq_m   = n_sat;
                        seq_raw = 1'b1;
                    end
                endcase
            end
            FUNC_GAP: begin
                seq_m = n_sat;
            end
            FUNC_PRESET: begin
                crc_preset = 1'b1;
            end
            FUNC_CRC: begin
                seq_v  = {{(DATA_W-CRC_W){1'b0}}, r_crc};
                seq_m  = CNT_W'(CRC_W);
                crc_en = 1'b1;
            end
            default: begin
                crc_preset = 1'b0;
            end
        endcase

        for (int i = 0; i < DATA_W; i++) begin
            len_mask[i] = (i < seq_m);
        end
        v_m      = seq_v & len_mask;
        ext_mask = {1'b0, len_mask};
        ext_v    = {1'b0, v_m};

        n_crc = r_crc;
        for (int p = DATA_W - 1; p >= 0; p--) begin
            if (crc_en && len_mask[p] && (!seq_raw || (p % 2 == 0))) begin
                n_crc = {n_crc[CRC_W-2:0], 1'b0}
                      ^ ((n_crc[CRC_W-1] ^ v_m[p]) ? CRC_POLY : '0);
            end
        end
        if (crc_preset) begin
            n_crc = CRC_PRESET;
        end

        for (int p = 0; p < DATA_W; p++) begin
            prev               = ext_mask[p+1] ? ext_v[p+1] : r_last;
            mfm_cells[2*p+1]   = len_mask[p] & ~(prev | v_m[p]);
            mfm_cells[2*p]     = v_m[p];
        end

        n_cells = seq_raw ? {{(CELL_W-DATA_W){1'b0}}, v_m} : mfm_cells;
        n_count = seq_raw ? {1'b0, seq_m} : {seq_m, 1'b0};
        n_last  = (seq_m != '0) ? v_m[0] : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (i_in.valid && i_in.ready) begin
                r_func  <= i_in.func;
                r_enc   <= i_in.encoding;
                r_cnt   <= i_in.bit_count;
                r_data  <= i_in.data_word;
                r_speed <= i_in.cell_speed;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_cells     <= n_cells;
                r_ccount    <= n_count;
                r_speed_out <= r_speed;
                r_crc       <= n_crc;
                r_last      <= n_last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
